// ----- hdl/esds_pkg.sv -----
// ----------------------------------------------------------------------------
// esds_pkg
// shared types, widths, register map and op codes of the scroll smoother
// ----------------------------------------------------------------------------
package esds_pkg;

    // fixed field widths
    localparam int DELTA_W = 16;
    localparam int EMIT_W  = 16;
    localparam int GAIN_W  = 12;
    localparam int EASE_W  = 16;
    localparam int THR_W   = 16;
    localparam int OWED_W  = 32;

    // default number of fraction bits of owed distance and carry
    localparam int FRAC_BITS_DEF = 8;

    // apb register port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam int IDX_W  = APB_AW - 2;

    localparam logic [IDX_W-1:0] REG_NOTCH_GAIN     = 2'd0;
    localparam logic [IDX_W-1:0] REG_EASING_FRACTION = 2'd1;
    localparam logic [IDX_W-1:0] REG_STOP_THRESHOLD = 2'd2;

    localparam logic [GAIN_W-1:0] NOTCH_GAIN_RST     = 12'd256;
    localparam logic [EASE_W-1:0] EASING_FRACTION_RST = 16'd11796;
    localparam logic [THR_W-1:0]  STOP_THRESHOLD_RST = 16'd128;

    // item op codes
    localparam logic OP_NOTCH = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [EMIT_W-1:0]  t_emit;

    typedef struct packed {
        logic [GAIN_W-1:0] notch_gain;
        logic [EASE_W-1:0] easing_fraction;
        logic [THR_W-1:0]  stop_threshold;
    } t_cfg;

    typedef struct packed {
        logic  emit;
        t_emit amount;
    } t_result;

endpackage

// ----- hdl/esds_if.sv -----
// ----------------------------------------------------------------------------
// esds stream interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface esds_in_if;
    import esds_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    t_delta wheel_delta;

    modport source (output valid, output op, output wheel_delta, input ready);
    modport sink (input valid, input op, input wheel_delta, output ready);
endinterface

interface esds_out_if;
    import esds_pkg::*;

    logic  valid;
    logic  ready;
    t_emit emit_amount;

    modport source (output valid, output emit_amount, input ready);
    modport sink (input valid, input emit_amount, output ready);
endinterface

// ----- hdl/esds_regs.sv -----
// ----------------------------------------------------------------------------
// esds_regs
// apb configuration registers: notch gain, easing fraction, stop threshold
// ----------------------------------------------------------------------------
module esds_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [esds_pkg::APB_AW-1:0]  paddr,
    input  logic [esds_pkg::APB_DW-1:0]  pwdata,
    output logic [esds_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output esds_pkg::t_cfg               o_cfg
);
    import esds_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign w_idx  = paddr[APB_AW-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.notch_gain      <= NOTCH_GAIN_RST;
            r_cfg.easing_fraction <= EASING_FRACTION_RST;
            r_cfg.stop_threshold  <= STOP_THRESHOLD_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_NOTCH_GAIN: begin
                    r_cfg.notch_gain <= pwdata[GAIN_W-1:0];
                end
                REG_EASING_FRACTION: begin
                    r_cfg.easing_fraction <= pwdata[EASE_W-1:0];
                end
                REG_STOP_THRESHOLD: begin
                    r_cfg.stop_threshold <= pwdata[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NOTCH_GAIN:      prdata = APB_DW'(r_cfg.notch_gain);
            REG_EASING_FRACTION: prdata = APB_DW'(r_cfg.easing_fraction);
            REG_STOP_THRESHOLD:  prdata = APB_DW'(r_cfg.stop_threshold);
            default:             prdata = '0;
        endcase
    end

endmodule

// ----- hdl/esds_core.sv -----
// ----------------------------------------------------------------------------
// esds_core
// owed distance and fraction carry state with the one-pass update datapath
// ----------------------------------------------------------------------------
module esds_core #(
    parameter int FRAC_BITS = esds_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_op,
    input  esds_pkg::t_delta  i_delta,
    input  esds_pkg::t_cfg    i_cfg,
    output esds_pkg::t_result o_result
);
    import esds_pkg::*;

    // format conversion from 8 fraction bits
    localparam int UP    = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
    localparam int DN    = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
    localparam int W_NP  = DELTA_W + GAIN_W + 1;
    localparam int W_NS  = W_NP + UP;
    localparam int W_SUM = ((W_NS > OWED_W) ? W_NS : OWED_W) + 1;
    localparam int W_TP  = OWED_W + EASE_W + 1;
    localparam int W_R   = OWED_W + 1;
    localparam int W_TH  = THR_W + UP;
    localparam int W_ACC = OWED_W + 1;
    localparam int W_WH  = W_ACC - FRAC_BITS;
    localparam int W_CY  = FRAC_BITS + 1;

    logic signed [OWED_W-1:0] r_owed;
    logic signed [W_CY-1:0]   r_carry;

    // notch path
    logic signed [W_NP-1:0]   w_nprod;
    logic signed [W_NP-1:0]   w_nbias;
    logic signed [W_NP-1:0]   w_nsh;
    logic signed [W_NS-1:0]   w_nscaled;
    logic signed [W_SUM-1:0]  w_sum;
    logic                     w_sum_fits;
    logic signed [OWED_W-1:0] w_owed_notch;

    // tick path
    logic signed [W_TP-1:0]   w_tprod;
    logic signed [W_TP-1:0]   w_tbias;
    logic signed [OWED_W-1:0] w_step0;
    logic signed [W_R-1:0]    w_rem;
    logic        [W_R-1:0]    w_abs;
    logic        [W_TH-1:0]   w_thr;
    logic                     w_flush;
    logic signed [OWED_W-1:0] w_step;
    logic signed [OWED_W-1:0] w_owed_tick;
    logic signed [W_ACC-1:0]  w_acc;
    logic signed [W_ACC-1:0]  w_abias;
    logic signed [W_WH-1:0]   w_whole;
    logic signed [W_CY-1:0]   w_carry_n;
    logic                     w_whole_fits;
    t_emit                    w_amount;

    // delta times gain, rescaled, saturating add into owed distance
    assign w_nprod   = W_NP'(i_delta) * W_NP'($signed({1'b0, i_cfg.notch_gain}));
    assign w_nbias   = w_nprod[W_NP-1] ? W_NP'((1 << DN) - 1) : '0;
    assign w_nsh     = (w_nprod + w_nbias) >>> DN;
    assign w_nscaled = W_NS'(w_nsh) <<< UP;
    assign w_sum     = W_SUM'(r_owed) + W_SUM'(w_nscaled);
    assign w_sum_fits = (w_sum[W_SUM-1:OWED_W-1] == '0) || (w_sum[W_SUM-1:OWED_W-1] == '1);

    always_comb begin
        if (w_sum_fits) begin
            w_owed_notch = w_sum[OWED_W-1:0];
        end else if (w_sum[W_SUM-1]) begin
            w_owed_notch = {1'b1, {(OWED_W-1){1'b0}}};
        end else begin
            w_owed_notch = {1'b0, {(OWED_W-1){1'b1}}};
        end
    end

    // eased step, truncated toward zero
    assign w_tprod = W_TP'(r_owed) * W_TP'($signed({1'b0, i_cfg.easing_fraction}));
    assign w_tbias = w_tprod[W_TP-1] ? W_TP'((1 << EASE_W) - 1) : '0;
    assign w_step0 = OWED_W'((w_tprod + w_tbias) >>> EASE_W);
    assign w_rem   = W_R'(r_owed) - W_R'(w_step0);
    assign w_abs   = w_rem[W_R-1] ? W_R'(-w_rem) : W_R'(w_rem);
    assign w_thr   = (W_TH'(i_cfg.stop_threshold) << UP) >> DN;
    assign w_flush = w_abs < W_R'(w_thr);

    // tail flush folds the remainder into the step: the step is the whole owed value
    assign w_step      = w_flush ? r_owed : w_step0;
    assign w_owed_tick = w_flush ? '0 : w_rem[OWED_W-1:0];

    // fraction accumulator
    assign w_acc     = W_ACC'(r_carry) + W_ACC'(w_step);
    assign w_abias   = w_acc[W_ACC-1] ? W_ACC'((1 << FRAC_BITS) - 1) : '0;
    assign w_whole   = W_WH'((w_acc + w_abias) >>> FRAC_BITS);
    assign w_carry_n = W_CY'(w_acc - (W_ACC'(w_whole) <<< FRAC_BITS));
    assign w_whole_fits = (w_whole[W_WH-1:EMIT_W-1] == '0) ||
                          (w_whole[W_WH-1:EMIT_W-1] == '1);

    always_comb begin
        if (w_whole_fits) begin
            w_amount = w_whole[EMIT_W-1:0];
        end else if (w_whole[W_WH-1]) begin
            w_amount = {1'b1, {(EMIT_W-1){1'b0}}};
        end else begin
            w_amount = {1'b0, {(EMIT_W-1){1'b1}}};
        end
    end

    assign o_result.emit   = (i_op == OP_TICK) && (w_whole != '0);
    assign o_result.amount = w_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed  <= '0;
            r_carry <= '0;
        end else if (i_adv) begin
            if (i_op == OP_NOTCH) begin
                r_owed <= w_owed_notch;
            end else begin
                r_owed  <= w_owed_tick;
                r_carry <= w_carry_n;
            end
        end
    end

endmodule

// ----- hdl/eased_scroll_delta_smoother.sv -----
// ----------------------------------------------------------------------------
// eased_scroll_delta_smoother
// flow: an accepted item waits in the input stage, a result it emits in the result stage
// throughput: one item per cycle unless a stalled result holds the input stage,
//   set by the owed distance and carry update loop through the easing multiplier
// reset: synchronous active low; owed distance and carry clear, registers
//   take their defaults, both stages empty
// ----------------------------------------------------------------------------
module eased_scroll_delta_smoother #(
    parameter int FRAC_BITS = esds_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    esds_in_if.sink                      in_if,
    esds_out_if.source                   out_if,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [esds_pkg::APB_AW-1:0]  paddr,
    input  logic [esds_pkg::APB_DW-1:0]  pwdata,
    output logic [esds_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import esds_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;

    // input stage: holds one accepted item
    logic    r_in_vld;
    logic    n_in_vld;
    logic    r_op;
    t_delta  r_delta;

    // result stage
    logic    r_out_vld;
    logic    n_out_vld;
    t_emit   r_amount;

    logic    w_adv;
    logic    w_in_xfer;

    // the held item moves on once the result slot is free or draining;
    // items with no result advance on the same condition
    assign w_adv       = r_in_vld && (!r_out_vld || out_if.ready);
    assign in_if.ready = !r_in_vld || w_adv;
    assign w_in_xfer   = in_if.valid && in_if.ready;

    assign out_if.valid       = r_out_vld;
    assign out_if.emit_amount = r_amount;

    esds_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    esds_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_op     (r_op),
        .i_delta  (r_delta),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_comb begin
        n_in_vld = w_in_xfer || (r_in_vld && !w_adv);
        if (w_adv) begin
            n_out_vld = w_result.emit;
        end else begin
            n_out_vld = r_out_vld && !out_if.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op    <= in_if.op;
            r_delta <= in_if.wheel_delta;
        end
        if (w_adv && w_result.emit) begin
            r_amount <= w_result.amount;
        end
    end

    // a held item with a stalled result must block new input
    a_stall_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !out_if.ready |-> !in_if.ready)
        else $error("input taken while held item is stalled");

    // a new result only follows a tick that advanced
    a_result_from_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(w_adv && (r_op == OP_TICK)))
        else $error("result appeared without an advancing tick");

    // emitted amounts are never zero
    a_nonzero_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_amount != '0))
        else $error("zero amount emitted");

    // an unread result is never overwritten
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !out_if.ready |=> r_out_vld && $stable(r_amount))
        else $error("pending result lost");

endmodule

// ----- verif/eased_scroll_delta_smoother_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eased_scroll_delta_smoother_tb
// drives wheel notches and frame ticks into the smoother, keeps a bit-true
// copy of the owed distance and carry arithmetic, and checks every emitted
// delta in order; the register port is written and read back between phases
// ----------------------------------------------------------------------------
module eased_scroll_delta_smoother_tb;
    import esds_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int SETTLE_CYCLES = 6;      // idle time for the pipe to settle after the last emit
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int RANDOM_PHASES = 8;

    // no register lives here, writes must be dropped
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam longint OWED_MAX = (longint'(1) <<< (OWED_W - 1)) - 1;
    localparam longint OWED_MIN = -(longint'(1) <<< (OWED_W - 1));
    localparam longint EMIT_MAX = (longint'(1) <<< (EMIT_W - 1)) - 1;
    localparam longint EMIT_MIN = -(longint'(1) <<< (EMIT_W - 1));

    logic i_clk;
    logic i_rst_n;

    // register port
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    esds_in_if  notch_ch ();
    esds_out_if emit_ch ();

    eased_scroll_delta_smoother i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_if   (notch_ch),
        .out_if  (emit_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the smoother state
    t_cfg   shadow_cfg;
    longint shadow_owed;     // owed distance, FRAC fraction bits
    longint shadow_carry;    // leftover fraction of emitted steps
    t_emit  pending_emits[$];

    int fail_count;
    int cycle_count;

    // pacing of both sides
    bit tx_bursty;
    int burst_left;
    bit rx_stalls;
    bit rx_open;
    int rx_run;

    t_emit oldest_emit;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // shadow arithmetic
    // ------------------------------------------------------------------

    // right shift that rounds toward zero for both signs
    function automatic longint shift_toward_zero(longint v, int s);
        if (v < 0) begin
            return -((-v) >>> s);
        end
        return v >>> s;
    endfunction

    // move a value with 8 fraction bits into the owed distance format
    function automatic longint q8_to_owed(longint v);
        if (FRAC >= 8) begin
            return v * (longint'(1) <<< (FRAC - 8));
        end
        return shift_toward_zero(v, 8 - FRAC);
    endfunction

    // advance the shadow by one accepted item, queueing the delta it emits
    function automatic void advance_scroll_shadow(logic op, t_delta delta);
        longint sum;
        longint owed;
        longint take;
        longint acc;
        longint whole;
        longint mag;
        if (op == OP_NOTCH) begin
            sum = shadow_owed + q8_to_owed(longint'(delta) * longint'(shadow_cfg.notch_gain));
            if (sum > OWED_MAX) begin
                sum = OWED_MAX;
            end
            if (sum < OWED_MIN) begin
                sum = OWED_MIN;
            end
            shadow_owed = sum;
            return;
        end
        // frame tick, the wheel delta plays no part
        if (shadow_owed == 0) begin
            return;
        end
        owed = shadow_owed;
        take = shift_toward_zero(owed * longint'(shadow_cfg.easing_fraction), 16);
        owed = owed - take;
        mag  = (owed < 0) ? -owed : owed;
        // tail below the stop threshold goes out with this frame
        if (mag < q8_to_owed(longint'(shadow_cfg.stop_threshold))) begin
            take = take + owed;
            owed = 0;
        end
        shadow_owed = owed;
        if (take == 0) begin
            return;
        end
        acc          = shadow_carry + take;
        whole        = shift_toward_zero(acc, FRAC);
        shadow_carry = acc - whole * (longint'(1) <<< FRAC);
        if (whole == 0) begin
            return;
        end
        if (whole > EMIT_MAX) begin
            whole = EMIT_MAX;
        end
        if (whole < EMIT_MIN) begin
            whole = EMIT_MIN;
        end
        pending_emits.push_back(t_emit'(whole));
    endfunction

    function automatic void report_failure(string what, longint want, longint got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                     cycle_count, what, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // result side: stall pattern and in-order check
    // ------------------------------------------------------------------

    // with stalls enabled the receiver alternates open and stalled runs of random length
    always @(negedge i_clk) begin
        if (!rx_stalls) begin
            emit_ch.ready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_open = !rx_open;
                rx_run  = rx_open ? $urandom_range(1, 8) : $urandom_range(1, 5);
            end
            rx_run--;
            emit_ch.ready <= rx_open;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && emit_ch.valid && emit_ch.ready) begin
            if (pending_emits.size() == 0) begin
                report_failure("emit transfer with nothing owed", 0, emit_ch.emit_amount);
            end else begin
                oldest_emit = pending_emits.pop_front();
                if (emit_ch.emit_amount !== oldest_emit) begin
                    report_failure("emit_amount", oldest_emit, emit_ch.emit_amount);
                end
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // item side
    // ------------------------------------------------------------------

    // drop valid for the given count, with junk on the payload meanwhile
    task automatic hold_input(int n);
        @(negedge i_clk);
        notch_ch.valid       <= 1'b0;
        notch_ch.op          <= 1'($urandom);
        notch_ch.wheel_delta <= t_delta'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // one transfer on the item channel, shadow updated at the accepting edge
    task automatic send_item(logic op, t_delta delta);
        if (tx_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                hold_input($urandom_range(1, 7));
            end
            burst_left--;
        end
        @(negedge i_clk);
        notch_ch.valid       <= 1'b1;
        notch_ch.op          <= op;
        notch_ch.wheel_delta <= delta;
        do @(posedge i_clk); while (!notch_ch.ready);
        advance_scroll_shadow(op, delta);
    endtask

    // stop sending and let every owed emit arrive, then let the pipe settle
    task automatic wait_until_drained();
        hold_input(1);
        while (pending_emits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    task automatic reg_write(logic [IDX_W-1:0] idx, logic [APB_DW-1:0] value);
        wait_until_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_NOTCH_GAIN:      shadow_cfg.notch_gain      = value[GAIN_W-1:0];
            REG_EASING_FRACTION: shadow_cfg.easing_fraction = value[EASE_W-1:0];
            REG_STOP_THRESHOLD:  shadow_cfg.stop_threshold  = value[THR_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(logic [IDX_W-1:0] idx, output logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read back all three registers against the shadow
    task automatic check_registers();
        logic [APB_DW-1:0] value;
        reg_read(REG_NOTCH_GAIN, value);
        if (value !== APB_DW'(shadow_cfg.notch_gain)) begin
            report_failure("notch_gain readback", shadow_cfg.notch_gain, value);
        end
        reg_read(REG_EASING_FRACTION, value);
        if (value !== APB_DW'(shadow_cfg.easing_fraction)) begin
            report_failure("easing_fraction readback", shadow_cfg.easing_fraction, value);
        end
        reg_read(REG_STOP_THRESHOLD, value);
        if (value !== APB_DW'(shadow_cfg.stop_threshold)) begin
            report_failure("stop_threshold readback", shadow_cfg.stop_threshold, value);
        end
    endtask

    task automatic set_config(logic [APB_DW-1:0] gain, logic [APB_DW-1:0] ease,
                              logic [APB_DW-1:0] thr);
        reg_write(REG_NOTCH_GAIN, gain);
        reg_write(REG_EASING_FRACTION, ease);
        reg_write(REG_STOP_THRESHOLD, thr);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // defaults after reset, ticks with nothing owed emit nothing
    task automatic test_reset_state();
        check_registers();
        send_item(OP_TICK, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000);
        wait_until_drained();
    endtask

    // extremes, masking of wide writes, unmapped address ignored
    task automatic test_register_access();
        set_config(32'h0000_0FFF, 32'h0000_FFFF, 32'h0000_FFFF);
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        check_registers();
        set_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        check_registers();
        set_config(32'hFFFF_F0A5, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        check_registers();
        set_config(32'(NOTCH_GAIN_RST), 32'(EASING_FRACTION_RST), 32'(STOP_THRESHOLD_RST));
        check_registers();
    endtask

    // ordinary notches of plus and minus 120 and one of zero, eased out over frames
    task automatic test_typical_scroll();
        int i;
        send_item(OP_NOTCH, 16'sd120);
        for (i = 0; i < 8; i++) send_item(OP_TICK, t_delta'($urandom));
        send_item(OP_NOTCH, -16'sd120);
        send_item(OP_NOTCH, -16'sd120);
        send_item(OP_NOTCH, 16'sd0);
        for (i = 0; i < 8; i++) send_item(OP_TICK, t_delta'($urandom));
        wait_until_drained();
    endtask

    task automatic test_special_cases();
        tx_bursty = 1'b1;
        rx_stalls = 1'b1;
        // zero easing: owed never moves while it sits above the threshold
        set_config(32'(NOTCH_GAIN_RST), 32'd0, 32'd0);
        send_item(OP_NOTCH, 16'sd120);
        send_item(OP_TICK, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000);
        // a huge threshold flushes the whole tail in one frame
        reg_write(REG_STOP_THRESHOLD, 32'h0000_FFFF);
        send_item(OP_TICK, 16'sd0);
        // a tiny owed value above the threshold gives a zero step
        set_config(32'd1, 32'(EASING_FRACTION_RST), 32'd0);
        send_item(OP_NOTCH, 16'sd1);
        send_item(OP_TICK, 16'sd5);
        send_item(OP_TICK, -16'sd5);
        reg_write(REG_STOP_THRESHOLD, 32'd2);
        send_item(OP_TICK, 16'sd0);
        // field extremes at the default gain
        set_config(32'(NOTCH_GAIN_RST), 32'(EASING_FRACTION_RST), 32'(STOP_THRESHOLD_RST));
        send_item(OP_NOTCH, 16'sh8000);
        send_item(OP_TICK, 16'sd0);
        send_item(OP_NOTCH, 16'sh7FFF);
        send_item(OP_TICK, 16'sh7FFF);
        send_item(OP_TICK, 16'sh8000);
        wait_until_drained();
        tx_bursty = 1'b0;
        rx_stalls = 1'b0;
    endtask

    // owed distance pinned at both ends, emit amount clipped at both ends
    task automatic test_saturation();
        int i;
        set_config(32'h0000_0FFF, 32'h0000_FFFF, 32'd0);
        for (i = 0; i < 17; i++) send_item(OP_NOTCH, 16'sh7FFF);
        for (i = 0; i < 3; i++) send_item(OP_TICK, t_delta'($urandom));
        for (i = 0; i < 18; i++) send_item(OP_NOTCH, 16'sh8000);
        for (i = 0; i < 3; i++) send_item(OP_TICK, t_delta'($urandom));
        wait_until_drained();
    endtask

    function automatic t_delta gesture_delta(int dir);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            return t_delta'(dir * 120);
        end
        if (r < 9) begin
            return t_delta'(dir * $urandom_range(1, 960));
        end
        return t_delta'($urandom);
    endfunction

    // one burst of stimulus: mostly a gesture (notches then frames), some noise or direction flips
    task automatic send_random_run(output int count);
        int kind;
        int n;
        int i;
        int dir;
        kind  = $urandom_range(0, 9);
        dir   = $urandom_range(0, 1) ? 1 : -1;
        count = 0;
        if (kind <= 6) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_item(OP_NOTCH, gesture_delta(dir));
            count += n;
            n = $urandom_range(3, 25);
            for (i = 0; i < n; i++) send_item(OP_TICK, t_delta'($urandom));
            count += n;
        end else if (kind <= 8) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) send_item(1'($urandom), t_delta'($urandom));
            count += n;
        end else begin
            // direction flips between single frames
            n = $urandom_range(2, 6);
            for (i = 0; i < n; i++) begin
                send_item(OP_NOTCH, t_delta'(((i % 2) ? -dir : dir) * 120));
                send_item(OP_TICK, t_delta'($urandom));
            end
            count += 2 * n;
        end
    endtask

    task automatic test_random_scrolling();
        int phase;
        int sent;
        int got;
        int per_phase;
        bit paused;
        per_phase  = RANDOM_ITEMS / RANDOM_PHASES;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: set_config(32'(NOTCH_GAIN_RST), 32'(EASING_FRACTION_RST),
                              32'(STOP_THRESHOLD_RST));
                1: set_config(32'h0000_0FFF, 32'h0000_FFFF, 32'h0000_FFFF);
                2: set_config(32'd0, 32'd0, 32'd0);
                3: set_config(32'd1, 32'd1, 32'd0);
                default: set_config($urandom_range(0, 4095), $urandom_range(0, 65535),
                                    $urandom_range(0, 65535));
            endcase
            // first phase runs flat out on both sides
            tx_bursty = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
            sent   = 0;
            paused = 1'b0;
            while (sent < per_phase) begin
                // odd phases hold the sender mid-way until all emits are out
                if ((phase % 2 == 1) && !paused && (sent >= per_phase / 2)) begin
                    wait_until_drained();
                    paused = 1'b1;
                end
                send_random_run(got);
                sent += got;
            end
        end
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        notch_ch.valid       = 1'b0;
        notch_ch.op          = OP_NOTCH;
        notch_ch.wheel_delta = '0;
        shadow_cfg.notch_gain      = NOTCH_GAIN_RST;
        shadow_cfg.easing_fraction = EASING_FRACTION_RST;
        shadow_cfg.stop_threshold  = STOP_THRESHOLD_RST;
        shadow_owed  = 0;
        shadow_carry = 0;
        tx_bursty    = 1'b0;
        burst_left   = 0;
        rx_stalls    = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_register_access();
        test_typical_scroll();
        test_special_cases();
        test_saturation();
        test_random_scrolling();
        wait_until_drained();

        if (fail_count == 0 && pending_emits.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
